>>> sv/bmr_pkg.sv
// Shared types, constants and helpers of the bridge converter reader.
// No dependencies; used by every module of the block.
package bmr_pkg;

	localparam int NUM_CHANNELS = 10;
	localparam int TARE_COUNT   = 10;
	localparam int CH_W         = $clog2(NUM_CHANNELS);
	localparam int DUMMY_CH     = NUM_CHANNELS - 1;
	localparam int SAMPLE_W     = 24;
	localparam int COMP_W       = SAMPLE_W + 1;
	localparam int GAIN_W       = 24;
	localparam int TMO_W        = 24;
	localparam int OFF_W        = 34;
	localparam int SUM_W        = 29;
	localparam int STRAIN_W     = 40;
	localparam int DIFF_W       = OFF_W + 1;
	localparam int PROD_W       = DIFF_W + GAIN_W;
	localparam int SHIFT_Q      = 16;
	localparam int PULSES       = 25;
	localparam int PC_W         = $clog2(PULSES + 1);
	localparam int TC_W         = $clog2(TARE_COUNT + 1);
	localparam int RW           = $clog2(TARE_COUNT + 1);
	localparam int FRAC_W       = 8;
	localparam int STATUS_W     = 2;
	localparam int CFG_IDX_W    = 2;

	// Reciprocal for floor(x / TARE_COUNT), exact for x < 2**SUM_W.
	localparam int REC_SH = SUM_W + $clog2(TARE_COUNT);
	localparam int REC_W  = REC_SH - $clog2(TARE_COUNT) + 2;
	localparam longint unsigned REC_M =
		((64'd1 << REC_SH) + TARE_COUNT - 1) / TARE_COUNT;

	localparam int IN_W  = 16;
	localparam int OUT_W = 104;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TARE    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_HIGH = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	typedef struct packed {
		logic                sck;
		logic                dvalid;
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] raw;
		logic [COMP_W-1:0]   comp;
		logic [STATUS_W-1:0] status;
		logic                busy;
		logic                last;
	} issue_t;

	typedef struct packed {
		logic              clr;
		logic              acc;
		logic              done;
		logic [CH_W-1:0]   ch;
		logic [COMP_W-1:0] comp;
	} tare_op_t;

	function automatic logic [FRAC_W-1:0] frac_of(logic [RW-1:0] r);
		frac_of = FRAC_W'((longint'(r) * 256 * REC_M) >> REC_SH);
	endfunction

endpackage

>>> sv/multichannel_bridge_adc_reader_unit.sv
// Ten-channel bridge converter reader: one input transfer per tick of the serial clock,
// one result per tick, or one result per channel when a conversion completes.
// Usage:
//   s_t*   : one transfer per tick; tdata = {tare_request, dout_pins}.
//   m_t*   : result transfers; tuser = data_valid, tlast marks the final result of a tick.
//   cfg_*  : register writes (0 enable, 1 strain_gain, 2 ready_timeout_ticks), always ready;
//            write only while the block is idle.
// Timing: a tick result passes the multiply stage and then the output register. A completion
//   tick yields its ten channel results, one per cycle while m_tready is high; s_tready
//   stays low while the channel results are issued.
// Throughput: one tick per cycle otherwise, limited by the issue slot of the strain
//   multiply stage.
// Reset: registers take their reset values, the reader waits idle with the clock low,
//   offsets and tare sums are zero.
// Stall: when m_tready is low the output register and the multiply stage hold; s_tready
//   drops once both are full, so nothing is lost.
// Depends on bmr_pkg, bmr_ctrl, bmr_tare, bmr_strain.
module multichannel_bridge_adc_reader_unit import bmr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // [9:0] dout_pins, [10] tare_request
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // [0] sck_level, [4:1] channel, [28:5] raw_sample,
	                                        // [53:29] compensated, [93:54] strain,
	                                        // [95:94] status, [96] tare_busy
	output logic [0:0]           m_tuser,   // [0] data_valid
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TMO_W-1:0]     cfg_data
);

	logic                     enable_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic [TMO_W-1:0]         timeout_q;
	logic                     in_fire, issue_ok, emit_busy, iss_valid;
	issue_t                   iss, out_meta;
	tare_op_t                 op;
	logic [OFF_W-1:0]         offset;
	logic [STRAIN_W-1:0]      out_strain;

	assign cfg_ready = 1'b1;
	assign s_tready  = !emit_busy && issue_ok;
	assign in_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			gain_q    <= GAIN_W'(65536);
			timeout_q <= TMO_W'(1000000);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ENABLE:  enable_q  <= cfg_data[0];
				CFG_GAIN:    gain_q    <= $signed(cfg_data);
				CFG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.pins      (s_tdata[NUM_CHANNELS-1:0]),
		.tare_req  (s_tdata[NUM_CHANNELS]),
		.enable    (enable_q),
		.timeout   (timeout_q),
		.issue_ok  (issue_ok),
		.emit_busy (emit_busy),
		.iss_valid (iss_valid),
		.iss       (iss),
		.op        (op)
	);

	bmr_tare u_tare (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.rd_ch  (iss.ch),
		.offset (offset)
	);

	bmr_strain u_strain (
		.clk        (clk),
		.arst_n     (arst_n),
		.iss_valid  (iss_valid),
		.iss        (iss),
		.offset     (offset),
		.gain       (gain_q),
		.issue_ok   (issue_ok),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_meta   (out_meta),
		.out_strain (out_strain)
	);

	assign m_tdata = {7'b0, out_meta.busy, out_meta.status, out_strain, out_meta.comp,
		out_meta.raw, out_meta.ch, out_meta.sck};
	assign m_tuser = out_meta.dvalid;
	assign m_tlast = out_meta.last;

`ifndef ASSERT_OFF
	a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_busy |-> !s_tready) else $error("tick accepted during channel issue");
	a_tick_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast) else $error("tick result not last");
	a_dummy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] && m_tdata[4:1] == CH_W'(DUMMY_CH)) |->
		(m_tdata[93:54] == '0 && m_tlast)) else $error("dummy channel result wrong");
`endif

endmodule

>>> sv/bmr_ctrl.sv
// Tick sequencer: ready wait, clock pulses, sampling, tare bookkeeping, result issue.
// Depends on bmr_pkg.
module bmr_ctrl import bmr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_fire,
	input  logic [NUM_CHANNELS-1:0] pins,
	input  logic                    tare_req,
	input  logic                    enable,
	input  logic [TMO_W-1:0]        timeout,
	input  logic                    issue_ok,
	output logic                    emit_busy,
	output logic                    iss_valid,
	output issue_t                  iss,
	output tare_op_t                op
);

	phase_t                phase_q, phase_d;
	logic [PC_W-1:0]       pc_q, pc_d;
	logic [SAMPLE_W-1:0]   sh_q [NUM_CHANNELS];
	logic [SAMPLE_W-1:0]   sh_d [NUM_CHANNELS];
	logic [TMO_W-1:0]      wc_q, wc_d, lim;
	logic                  tact_q, tact_d;
	logic [TC_W-1:0]       tcnt_q, tcnt_d;
	logic                  emit_q, emit_d;
	logic [CH_W-1:0]       ech_q, ech_d;
	logic                  eacc_q, eacc_d, edone_q, edone_d, ebusy_q, ebusy_d;
	logic [STATUS_W-1:0]   est_q, est_d;
	logic                  req_take;
	logic signed [COMP_W-1:0] raw_sel, raw_dum;

	assign emit_busy = emit_q;
	assign lim       = (timeout == '0) ? TMO_W'(1) : timeout;
	assign raw_sel   = COMP_W'($signed(sh_q[ech_q]));
	assign raw_dum   = COMP_W'($signed(sh_q[DUMMY_CH]));

	always_comb begin
		phase_d   = phase_q;
		pc_d      = pc_q;
		sh_d      = sh_q;
		wc_d      = wc_q;
		tact_d    = tact_q;
		tcnt_d    = tcnt_q;
		emit_d    = emit_q;
		ech_d     = ech_q;
		eacc_d    = eacc_q;
		edone_d   = edone_q;
		ebusy_d   = ebusy_q;
		est_d     = est_q;
		iss       = '0;
		iss_valid = 1'b0;
		op        = '0;
		req_take  = in_fire && tare_req && !tact_q;
		if (req_take) begin
			tact_d = 1'b1;
			tcnt_d = '0;
			op.clr = 1'b1;
		end
		if (in_fire) begin
			iss_valid = 1'b1;
			iss.last  = 1'b1;
			unique case (phase_q)
				PH_IDLE: begin
					if (enable && pins == '0) begin
						for (int i = 0; i < NUM_CHANNELS; i++) sh_d[i] = '0;
						pc_d    = '0;
						wc_d    = '0;
						phase_d = PH_HIGH;
						iss.sck = 1'b1;
					end else if (enable) begin
						wc_d = wc_q + TMO_W'(1);
						if (wc_d >= lim) begin
							iss.status = ST_TIMEOUT;
							wc_d       = '0;
						end
					end else begin
						wc_d = '0;
					end
				end
				PH_LOW: begin
					phase_d = PH_HIGH;
					iss.sck = 1'b1;
				end
				PH_HIGH: begin
					if (pc_q < PC_W'(SAMPLE_W)) begin
						for (int i = 0; i < NUM_CHANNELS; i++)
							sh_d[i] = sh_q[i] | (SAMPLE_W'(pins[i])
								<< (PC_W'(SAMPLE_W - 1) - pc_q));
					end
					pc_d = pc_q + PC_W'(1);
					if (pc_q < PC_W'(PULSES - 1)) begin
						phase_d = PH_LOW;
					end else begin
						// completion: channel results follow from the emit counter
						phase_d   = PH_IDLE;
						pc_d      = '0;
						iss_valid = 1'b0;
						eacc_d    = tact_d;
						edone_d   = 1'b0;
						est_d     = ST_OK;
						if (tact_d) begin
							tcnt_d = tcnt_d + TC_W'(1);
							if (tcnt_d >= TC_W'(TARE_COUNT)) begin
								tact_d  = 1'b0;
								tcnt_d  = '0;
								est_d   = ST_TARE;
								edone_d = 1'b1;
							end
						end
						ebusy_d = tact_d;
						emit_d  = 1'b1;
						ech_d   = '0;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
			iss.busy = tact_d;
		end else if (emit_q && issue_ok) begin
			iss_valid  = 1'b1;
			iss.dvalid = 1'b1;
			iss.ch     = ech_q;
			iss.raw    = sh_q[ech_q];
			iss.comp   = (ech_q == CH_W'(DUMMY_CH)) ? '0 : raw_sel - raw_dum;
			iss.status = est_q;
			iss.busy   = ebusy_q;
			iss.last   = (ech_q == CH_W'(DUMMY_CH));
			op.acc     = eacc_q && (ech_q != CH_W'(DUMMY_CH));
			op.done    = edone_q;
			op.ch      = ech_q;
			op.comp    = iss.comp;
			ech_d      = ech_q + CH_W'(1);
			if (iss.last) emit_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pc_q    <= '0;
			wc_q    <= '0;
			tact_q  <= 1'b0;
			tcnt_q  <= '0;
			emit_q  <= 1'b0;
			ech_q   <= '0;
			eacc_q  <= 1'b0;
			edone_q <= 1'b0;
			ebusy_q <= 1'b0;
			est_q   <= ST_OK;
			for (int i = 0; i < NUM_CHANNELS; i++) sh_q[i] <= '0;
		end else begin
			phase_q <= phase_d;
			pc_q    <= pc_d;
			wc_q    <= wc_d;
			tact_q  <= tact_d;
			tcnt_q  <= tcnt_d;
			emit_q  <= emit_d;
			ech_q   <= ech_d;
			eacc_q  <= eacc_d;
			edone_q <= edone_d;
			ebusy_q <= ebusy_d;
			est_q   <= est_d;
			sh_q    <= sh_d;
		end
	end

endmodule

>>> sv/bmr_tare.sv
// Tare sums and Q.8 offsets; offset = trunc(sum*256/TARE_COUNT) via reciprocal pipeline.
// Depends on bmr_pkg.
module bmr_tare import bmr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tare_op_t             op,
	input  logic [CH_W-1:0]      rd_ch,
	output logic [OFF_W-1:0]     offset
);

	logic signed [SUM_W-1:0] sums_q [NUM_CHANNELS-1];
	logic [OFF_W-1:0]        offs_q [NUM_CHANNELS-1];
	logic signed [SUM_W-1:0] sum_new;
	logic                    v_p1, v_p2, v_p3;
	logic                    neg_p1, neg_p2, neg_p3;
	logic [CH_W-1:0]         ch_p1, ch_p2, ch_p3;
	logic [SUM_W-1:0]        abs_p1, abs_p2, q_p2, q_p3;
	logic [RW-1:0]           r_p3;
	logic [SUM_W+REC_W-1:0]  qprod;
	logic [SUM_W-1:0]        qt;
	logic [SUM_W+FRAC_W-1:0] mag;

	assign offset  = (rd_ch == CH_W'(DUMMY_CH)) ? '0 : offs_q[rd_ch];
	assign sum_new = (op.clr ? SUM_W'(0) : sums_q[op.ch]) + SUM_W'($signed(op.comp));
	assign qprod   = (SUM_W + REC_W)'(abs_p1) * (SUM_W + REC_W)'(REC_M);
	assign qt      = abs_p2 - SUM_W'(q_p2 * SUM_W'(TARE_COUNT));
	assign mag     = {q_p3, FRAC_W'(0)} + (SUM_W + FRAC_W)'(frac_of(r_p3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS - 1; i++) begin
				sums_q[i] <= '0;
				offs_q[i] <= '0;
			end
		end else begin
			if (op.clr) begin
				for (int i = 0; i < NUM_CHANNELS - 1; i++) sums_q[i] <= '0;
			end
			if (op.acc) sums_q[op.ch] <= sum_new;
			v_p1 <= op.acc && op.done;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			if (v_p3) offs_q[ch_p3] <= neg_p3 ? OFF_W'(-mag) : OFF_W'(mag);
		end
	end

	always_ff @(posedge clk) begin
		neg_p1 <= sum_new[SUM_W-1];
		abs_p1 <= sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
		ch_p1  <= op.ch;
		neg_p2 <= neg_p1;
		abs_p2 <= abs_p1;
		ch_p2  <= ch_p1;
		q_p2   <= SUM_W'(qprod >> REC_SH);
		neg_p3 <= neg_p2;
		ch_p3  <= ch_p2;
		q_p3   <= q_p2;
		r_p3   <= qt[RW-1:0];
	end

endmodule

>>> sv/bmr_strain.sv
// Strain pipeline: multiply stage and saturating output register with stream handshake.
// Depends on bmr_pkg.
module bmr_strain import bmr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       iss_valid,
	input  issue_t                     iss,
	input  logic [OFF_W-1:0]           offset,
	input  logic signed [GAIN_W-1:0]   gain,
	output logic                       issue_ok,
	output logic                       out_valid,
	input  logic                       out_ready,
	output issue_t                     out_meta,
	output logic [STRAIN_W-1:0]        out_strain
);

	logic                        v_s1, ov_q, out_load;
	issue_t                      meta_s1;
	logic                        zero_s1;
	logic signed [PROD_W-1:0]    prod_s1;
	logic signed [DIFF_W-1:0]    diff;
	logic signed [PROD_W-SHIFT_Q-1:0] shv;
	logic [STRAIN_W-1:0]         sat;

	localparam logic signed [PROD_W-SHIFT_Q-1:0] SMAX =
		(PROD_W - SHIFT_Q)'({1'b0, {(STRAIN_W-1){1'b1}}});
	localparam logic signed [PROD_W-SHIFT_Q-1:0] SMIN = -SMAX - 1;

	assign out_load  = v_s1 && (!ov_q || out_ready);
	assign issue_ok  = !v_s1 || out_load;
	assign out_valid = ov_q;
	assign diff      = (DIFF_W'($signed(iss.comp)) <<< 8) - DIFF_W'($signed(offset));
	assign shv       = (PROD_W - SHIFT_Q)'(prod_s1 >>> SHIFT_Q);

	always_comb begin
		priority if (zero_s1) sat = '0;
		else if (shv > SMAX)  sat = SMAX[STRAIN_W-1:0];
		else if (shv < SMIN)  sat = SMIN[STRAIN_W-1:0];
		else                  sat = shv[STRAIN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (iss_valid)     v_s1 <= 1'b1;
			else if (out_load) v_s1 <= 1'b0;
			if (out_load)       ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (iss_valid) begin
			meta_s1 <= iss;
			zero_s1 <= !iss.dvalid || (iss.ch == CH_W'(DUMMY_CH));
			prod_s1 <= PROD_W'(diff) * PROD_W'(gain);
		end
		if (out_load) begin
			out_meta   <= meta_s1;
			out_strain <= sat;
		end
	end

endmodule
